FILE: design/sssf_pkg.sv
// Package for the seven-segment scan unit: opcodes, register indexes,
// shared structs and the BCD to segment decoder. No dependencies.
package sssf_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int POS_W      = 3;
  localparam int CNT_W      = 4;
  localparam int SEG_W      = 8;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_WRITE   = 2'd1,
    OP_TOGGLE  = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LAST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 2'd3;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

  // image update request from the item stage
  typedef struct packed {
    logic             clear;
    logic             wr;
    logic             toggle;
    logic [POS_W-1:0] pos;
    logic [SEG_W-1:0] shape;
  } img_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]    first;
    logic [POS_W-1:0]    last;
    logic [PERIOD_W-1:0] period;
  } flash_cfg_t;

  // segments a..g on bits 0..6; anything above 9 is blank
  function automatic logic [SEG_W-1:0] bcd_to_seg(input logic [3:0] bcd);
    logic [SEG_W-1:0] seg;
    case (bcd)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

FILE: design/sssf_image_store.sv
// Per-digit segment image registers with clear, write and point toggle.
// Depends on sssf_pkg.
module sssf_image_store
  import sssf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  img_cmd_t         cmd,
  input  logic [POS_W-1:0] rd_pos,
  output logic [SEG_W-1:0] rd_data
);

  logic [SEG_W-1:0] img_r   [MAX_DIGITS];
  logic [SEG_W-1:0] img_nxt [MAX_DIGITS];

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      img_nxt[i] = img_r[i];
      if (cmd.clear) begin
        img_nxt[i] = '0;
      end else if (cmd.wr && (cmd.pos == POS_W'(i))) begin
        img_nxt[i] = cmd.shape;
      end else if (cmd.toggle && (cmd.pos == POS_W'(i))) begin
        img_nxt[i] = img_r[i] ^ POINT_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (!rst_n) begin
        img_r[i] <= '0;
      end else begin
        img_r[i] <= img_nxt[i];
      end
    end
  end

  assign rd_data = img_r[rd_pos];

endmodule

FILE: design/sssf_scan_ctrl.sv
// Scan position, flash frame counter and flash blanking decision.
// Depends on sssf_pkg.
module sssf_scan_ctrl
  import sssf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CNT_W-1:0] count,
  input  flash_cfg_t       flash,
  input  logic             flash_clr,
  output logic [POS_W-1:0] pos_new,
  output logic             blank
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [PERIOD_W-1:0] fc_r, fc_nxt;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    wrapped;
  logic [PERIOD_W:0]   fc_inc;
  logic [PERIOD_W-1:0] fc_wrap, fc_step;
  logic                flash_on;

  // (pos + 1) mod count; position may sit above a freshly lowered count.
  // rem is 1..8 and count is 1..8, so only counts of 4 or less need more
  // than one subtract; 2 and 4 are masks.
  always_comb begin
    rem = {1'b0, pos_r} + CNT_W'(1);
    case (count)
      4'd1: wrapped = '0;
      4'd2: wrapped = {3'b000, rem[0]};
      4'd3: begin
        if (rem >= CNT_W'(6)) begin
          wrapped = rem - CNT_W'(6);
        end else if (rem >= CNT_W'(3)) begin
          wrapped = rem - CNT_W'(3);
        end else begin
          wrapped = rem;
        end
      end
      4'd4: wrapped = {2'b00, rem[1:0]};
      default: begin
        wrapped = (rem >= count) ? rem - count : rem;
      end
    endcase
  end

  assign pos_new  = wrapped[POS_W-1:0];
  assign flash_on = (flash.period != '0);
  assign fc_inc   = {1'b0, fc_r} + (PERIOD_W+1)'(1);
  // counter stays below period, so one compare does the wrap
  assign fc_wrap  = (fc_inc == {1'b0, flash.period}) ? '0 : fc_inc[PERIOD_W-1:0];
  assign fc_step  = (flash_on && (pos_new == '0)) ? fc_wrap : fc_r;

  assign blank = flash_on && (pos_new >= flash.first) && (pos_new <= flash.last) &&
                 (fc_step > (flash.period >> 1));

  always_comb begin
    pos_nxt = step ? pos_new : pos_r;
    if (flash_clr) begin
      fc_nxt = '0;
    end else if (step) begin
      fc_nxt = fc_step;
    end else begin
      fc_nxt = fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_W'(MAX_DIGITS - 1);
      fc_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      fc_r  <= fc_nxt;
    end
  end

endmodule

FILE: design/seven_segment_scan_with_flash_unit.sv
// Top level of the multiplexed seven-segment scanner with flash window.
// Depends on sssf_pkg, sssf_image_store and sssf_scan_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transfer:
//   clear all images, write a BCD digit at a position, toggle the decimal
//   point at a position, or a refresh tick. Only a refresh tick produces a
//   result transfer on the output channel (out_segments, out_digit_select).
//   Config port: cfg_we with cfg_index / cfg_data, single-cycle writes; the
//   user must issue them only while the unit is idle, which the block does
//   not enforce. Writing a flash register clears the flash frame counter.
//   Path: a transferred item is held in the item register; a refresh tick
//   then moves into the output register, which sets out_valid, once the
//   output is not both full and stalled.
//   Throughput: one item per cycle while in_stall is low; every operation
//   passes once through the item register and the image/scan update logic;
//   a refresh tick also passes through the output register.
//   Stall: the output register holds its result while out_stall is high.
//   Non-refresh items keep flowing; a refresh tick waits in the item
//   register, and in_stall rises, only while the output is full and stalled.
//   Reset: synchronous, active low. Images cleared, scan position at the
//   last digit, flash counter zero, config at defaults (8 digits, flashing
//   off). in_stall is held high during reset.
module seven_segment_scan_with_flash_unit
  import sssf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [POS_W-1:0]      in_position,
  input  logic [3:0]            in_bcd_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SEG_W-1:0]      out_segments,
  output logic [POS_W-1:0]      out_digit_select,
  // config
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [CNT_W-1:0] digit_count_r, digit_count_nxt;
  flash_cfg_t       flash_r, flash_nxt;
  logic             flash_clr;

  // item register
  logic             s1_valid_r, s1_valid_nxt;
  op_t              s1_op_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [3:0]       s1_bcd_r;
  logic             s1_load;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [SEG_W-1:0] out_seg_r;
  logic [POS_W-1:0] out_sel_r;
  logic             out_load;

  logic [CNT_W-1:0] used_cnt;
  logic             adv;
  img_cmd_t         img_cmd;
  logic [POS_W-1:0] scan_pos;
  logic             scan_blank;
  logic [SEG_W-1:0] img_data;

  // ---------------- config ----------------
  always_comb begin
    digit_count_nxt = digit_count_r;
    flash_nxt       = flash_r;
    flash_clr       = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DIGIT_COUNT: digit_count_nxt = cfg_data[CNT_W-1:0];
        CFG_FLASH_FIRST: begin
          flash_nxt.first = cfg_data[POS_W-1:0];
          flash_clr       = 1'b1;
        end
        CFG_FLASH_LAST: begin
          flash_nxt.last = cfg_data[POS_W-1:0];
          flash_clr      = 1'b1;
        end
        CFG_FLASH_PERIOD: begin
          flash_nxt.period = cfg_data[PERIOD_W-1:0];
          flash_clr        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= CNT_W'(MAX_DIGITS);
      flash_r       <= '0;
    end else begin
      digit_count_r <= digit_count_nxt;
      flash_r       <= flash_nxt;
    end
  end

  // zero scans as one digit, anything past the display as the full display
  assign used_cnt = (digit_count_r == '0) ? CNT_W'(1) :
                    (digit_count_r > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) :
                    digit_count_r;

  // ---------------- item register ----------------
  // refresh needs a free (or draining) output slot; other ops always go
  assign adv      = s1_valid_r &&
                    ((s1_op_r != OP_REFRESH) || !out_valid_r || !out_stall);
  assign in_stall = !rst_n || (s1_valid_r && !adv);
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r  <= op_t'(in_operation);
      s1_pos_r <= in_position;
      s1_bcd_r <= in_bcd_value;
    end
  end

  // ---------------- image and scan update ----------------
  always_comb begin
    img_cmd.clear  = adv && (s1_op_r == OP_CLEAR);
    img_cmd.wr     = adv && (s1_op_r == OP_WRITE) && ({1'b0, s1_pos_r} < used_cnt);
    img_cmd.toggle = adv && (s1_op_r == OP_TOGGLE);
    img_cmd.pos    = s1_pos_r;
    img_cmd.shape  = bcd_to_seg(s1_bcd_r);
  end

  assign out_load = adv && (s1_op_r == OP_REFRESH);

  sssf_image_store u_images (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (img_cmd),
    .rd_pos  (scan_pos),
    .rd_data (img_data)
  );

  sssf_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (out_load),
    .count     (used_cnt),
    .flash     (flash_r),
    .flash_clr (flash_clr),
    .pos_new   (scan_pos),
    .blank     (scan_blank)
  );

  // ---------------- output register ----------------
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_seg_r <= scan_blank ? '0 : img_data;
      out_sel_r <= scan_pos;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_seg_r;
  assign out_digit_select = out_sel_r;

endmodule

FILE: design/sssf_checker.sv
// Port-level checks for the seven-segment scan unit, bound to the top.
// Depends on sssf_pkg and seven_segment_scan_with_flash_unit.
module sssf_checker
  import sssf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [1:0]            in_operation,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [SEG_W-1:0]      out_segments,
  input logic [POS_W-1:0]      out_digit_select
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_segments) &&
                               $stable(out_digit_select))
    else $error("stalled result changed");

  // a new result only appears after a refresh transfer has passed through the item register
  a_out_from_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && (in_operation == OP_REFRESH), 2))
    else $error("result without a refresh tick");

  // input backpressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind seven_segment_scan_with_flash_unit sssf_checker u_sssf_checker (.*);
